[rtl/fend_pkg.sv]
// Shared types, constants and helpers for the frame energy novelty detector.
`default_nettype none
package fend_pkg;

	localparam int FRAME_MAX   = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int SMP_USE     = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
	localparam int SMP_SHIFT   = 16 - SMP_USE;

	localparam int SMP_W   = 16;
	localparam int RMS_W   = 16;
	localparam int SCORE_W = 17;
	localparam int BASE_W  = 17;
	localparam int WGT_W   = 16;
	localparam int SUM_W   = 44;
	localparam int PROD_W  = 2 * BASE_W;
	localparam int CNT_W   = $clog2(FRAME_MAX + 1);
	localparam int FRAC_W  = 16;

	localparam int DIV_STEPS  = SUM_W;
	localparam int SQRT_STEPS = RMS_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam logic [BASE_W-1:0]  ONE_Q16    = BASE_W'(1 << FRAC_W);
	localparam logic [SCORE_W-1:0] HALF_SCORE = SCORE_W'(1 << (FRAC_W - 1));
	localparam logic [WGT_W-1:0]   BW_RESET   = WGT_W'(655);
	localparam logic [WGT_W-1:0]   AW_RESET   = WGT_W'(6554);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_BASELINE_WEIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_WEIGHT  = 1'd1;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic                    frame_end;
	} smp_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] frame_score;
		logic [RMS_W-1:0]   rms_energy;
		logic [SCORE_W-1:0] average_novelty;
		logic               first_frame;
		logic               frame_overflow;
	} res_item_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQUARE,
		OP_ACCUM,
		OP_MEAN_START,
		OP_DIV_STEP,
		OP_SQRT_START,
		OP_SQRT_STEP,
		OP_SCORE_START,
		OP_SCORE_TAKE,
		OP_MUL_OLD_B,
		OP_MUL_NEW_B,
		OP_SUM_B,
		OP_MUL_OLD_A,
		OP_MUL_NEW_A,
		OP_SUM_A,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic step_last;
		logic score_div;
		logic out_free;
	} dp_sts_t;

	// Q1.15 magnitude of a sample, from 0 to 32768.
	function automatic logic [RMS_W-1:0] sample_mag(logic [SMP_W-1:0] raw);
		logic [SMP_USE-1:0] v;
		logic [SMP_USE:0]   m;
		v = raw[SMP_USE-1:0];
		if (v[SMP_USE-1]) begin
			m = {1'b1, {SMP_USE{1'b0}}} - {1'b0, v};
		end else begin
			m = {1'b0, v};
		end
		return RMS_W'(m) << SMP_SHIFT;
	endfunction

endpackage
`default_nettype wire

[rtl/fend_div.sv]
// Restoring divider, one quotient bit per step.
`default_nettype none
module fend_div
	import fend_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              start,
	input  wire logic              step,
	input  wire logic [SUM_W-1:0]  dividend,
	input  wire logic [BASE_W-1:0] divisor,
	output logic      [SUM_W-1:0]  quotient
);

	logic [SUM_W-1:0]  quo_q;
	logic [BASE_W-1:0] rem_q;
	logic [BASE_W-1:0] dvs_q;
	logic [BASE_W:0]   rem_sh;
	logic [BASE_W:0]   rem_sub;
	logic              fits;

	assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
	assign fits    = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step) begin
			rem_q <= fits ? rem_sub[BASE_W-1:0] : rem_sh[BASE_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule
`default_nettype wire

[rtl/fend_dp.sv]
// Datapath: accumulation, mean divide, square root, score, baseline and average blends.
`default_nettype none
module fend_dp
	import fend_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_cmd_t              cmd,
	output dp_sts_t                   sts,
	input  wire smp_item_t            smp_item,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output res_item_t                 res_item,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WGT_W-1:0]     cfg_data
);

	logic [WGT_W-1:0]   wb_q, wa_q;
	logic [RMS_W-1:0]   mag_q;
	logic               last_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;
	logic [BASE_W-1:0]  base_q;
	logic               bvalid_q;
	logic [SCORE_W-1:0] avg_q;
	logic [SCORE_W-1:0] score_q;
	logic               first_q;
	logic [STEP_W-1:0]  step_q;
	logic [31:0]        rad_q;
	logic [RMS_W+1:0]   rem_q;
	logic [RMS_W-1:0]   root_q;
	logic [PROD_W-1:0]  pa_q, pb_q;
	logic               res_valid_q;
	res_item_t          res_q;

	logic [BASE_W-1:0]  mul_x, mul_y;
	logic [PROD_W-1:0]  product;
	logic [SUM_W:0]     sum_add;
	logic [PROD_W:0]    blend_sum;
	logic [BASE_W-1:0]  e_val;
	logic [BASE_W-1:0]  diff;
	logic               div_start;
	logic [SUM_W-1:0]   div_dividend;
	logic [BASE_W-1:0]  div_divisor;
	logic [SUM_W-1:0]   quotient;
	logic [RMS_W+3:0]   sq_sh;
	logic [RMS_W+3:0]   sq_trial;
	logic [RMS_W+3:0]   sq_sub;
	logic               sq_fits;
	logic               out_free;

	assign e_val = {root_q, 1'b0};
	assign diff  = (e_val >= base_q) ? (e_val - base_q) : (base_q - e_val);

	// Single shared multiplier
	always_comb begin
		mul_x = '0;
		mul_y = '0;
		case (cmd.op)
			OP_SQUARE: begin
				mul_x = BASE_W'(mag_q);
				mul_y = BASE_W'(mag_q);
			end
			OP_MUL_OLD_B: begin
				mul_x = base_q;
				mul_y = ONE_Q16 - BASE_W'(wb_q);
			end
			OP_MUL_NEW_B: begin
				mul_x = e_val;
				mul_y = BASE_W'(wb_q);
			end
			OP_MUL_OLD_A: begin
				mul_x = avg_q;
				mul_y = ONE_Q16 - BASE_W'(wa_q);
			end
			OP_MUL_NEW_A: begin
				mul_x = score_q;
				mul_y = BASE_W'(wa_q);
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end
	assign product = mul_x * mul_y;

	assign sum_add   = {1'b0, sum_q} + (SUM_W + 1)'(pa_q);
	assign blend_sum = (PROD_W + 1)'(pa_q) + (PROD_W + 1)'(pb_q)
	                 + (PROD_W + 1)'(1 << (FRAC_W - 1));

	assign div_start    = (cmd.op == OP_MEAN_START) || (cmd.op == OP_SCORE_START);
	assign div_dividend = (cmd.op == OP_SCORE_START) ? (SUM_W'({diff, {FRAC_W{1'b0}}})) : sum_q;
	assign div_divisor  = (cmd.op == OP_SCORE_START) ? base_q :
	                      ((cnt_q == '0) ? BASE_W'(1) : BASE_W'(cnt_q));

	fend_div u_div (
		.clk      (clk),
		.start    (div_start),
		.step     (cmd.op == OP_DIV_STEP),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient)
	);

	// Digit-by-digit square root, two radicand bits per step
	assign sq_sh    = {rem_q, rad_q[31:30]};
	assign sq_trial = (RMS_W + 4)'({root_q, 2'b01});
	assign sq_fits  = sq_sh >= sq_trial;
	assign sq_sub   = sq_sh - sq_trial;

	assign out_free = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q        <= BW_RESET;
			wa_q        <= AW_RESET;
			sum_q       <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			base_q      <= '0;
			bvalid_q    <= 1'b0;
			avg_q       <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_BASELINE_WEIGHT: wb_q <= cfg_data;
					REG_AVERAGE_WEIGHT:  wa_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == OP_EMIT) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (cmd.op) inside
				OP_ACCUM: begin
					if (cnt_q < CNT_W'(FRAME_MAX)) begin
						sum_q <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				OP_MEAN_START, OP_SCORE_START: step_q <= STEP_W'(DIV_STEPS - 1);
				OP_SQRT_START:                 step_q <= STEP_W'(SQRT_STEPS - 1);
				OP_DIV_STEP, OP_SQRT_STEP:     step_q <= step_q - STEP_W'(1);
				OP_SUM_B: begin
					base_q   <= blend_sum[FRAC_W+BASE_W-1:FRAC_W];
					bvalid_q <= 1'b1;
				end
				OP_SUM_A: avg_q <= blend_sum[FRAC_W+SCORE_W-1:FRAC_W];
				OP_EMIT: begin
					sum_q <= '0;
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op) inside
			OP_LOAD: begin
				mag_q  <= sample_mag(smp_item.sample);
				last_q <= smp_item.frame_end;
			end
			OP_SQUARE, OP_MUL_OLD_B, OP_MUL_OLD_A: pa_q <= product;
			OP_MUL_NEW_B, OP_MUL_NEW_A:            pb_q <= product;
			OP_SQRT_START: begin
				rad_q  <= quotient[31:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_SQRT_STEP: begin
				rad_q  <= {rad_q[29:0], 2'b00};
				rem_q  <= sq_fits ? sq_sub[RMS_W+1:0] : sq_sh[RMS_W+1:0];
				root_q <= {root_q[RMS_W-2:0], sq_fits};
			end
			OP_SCORE_START: begin
				first_q <= !bvalid_q;
				if (!bvalid_q) begin
					score_q <= HALF_SCORE;
				end else if (e_val != '0) begin
					score_q <= ONE_Q16;
				end else begin
					score_q <= '0;
				end
			end
			OP_SCORE_TAKE: begin
				score_q <= (quotient > SUM_W'(ONE_Q16)) ? ONE_Q16 : quotient[SCORE_W-1:0];
			end
			OP_EMIT: begin
				res_q.frame_score     <= score_q;
				res_q.rms_energy      <= root_q;
				res_q.average_novelty <= avg_q;
				res_q.first_frame     <= first_q;
				res_q.frame_overflow  <= ovf_q;
			end
			default: ;
		endcase
	end

	assign sts.last      = last_q;
	assign sts.step_last = (step_q == '0);
	assign sts.score_div = bvalid_q && (base_q != '0);
	assign sts.out_free  = out_free;

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule
`default_nettype wire

[rtl/fend_ctrl.sv]
// Controller: sequences sample accumulation and frame-end processing.
`default_nettype none
module fend_ctrl
	import fend_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    smp_valid,
	output logic         smp_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_SQR    = 17'h00002,
		S_ACC    = 17'h00004,
		S_MEAN   = 17'h00008,
		S_MDIV   = 17'h00010,
		S_ROOT   = 17'h00020,
		S_RSTEP  = 17'h00040,
		S_SCORE  = 17'h00080,
		S_SDIV   = 17'h00100,
		S_SCLAMP = 17'h00200,
		S_BLB1   = 17'h00400,
		S_BLB2   = 17'h00800,
		S_BLB3   = 17'h01000,
		S_BLA1   = 17'h02000,
		S_BLA2   = 17'h04000,
		S_BLA3   = 17'h08000,
		S_EMIT   = 17'h10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (smp_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_SQR;
				end
			end
			S_SQR: begin
				cmd.op  = OP_SQUARE;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.op  = OP_ACCUM;
				state_d = sts.last ? S_MEAN : S_IDLE;
			end
			S_MEAN: begin
				cmd.op  = OP_MEAN_START;
				state_d = S_MDIV;
			end
			S_MDIV: begin
				cmd.op = OP_DIV_STEP;
				if (sts.step_last) begin
					state_d = S_ROOT;
				end
			end
			S_ROOT: begin
				cmd.op  = OP_SQRT_START;
				state_d = S_RSTEP;
			end
			S_RSTEP: begin
				cmd.op = OP_SQRT_STEP;
				if (sts.step_last) begin
					state_d = S_SCORE;
				end
			end
			S_SCORE: begin
				// fixed score is set here; the divide only runs against a live baseline
				cmd.op  = OP_SCORE_START;
				state_d = sts.score_div ? S_SDIV : S_BLB1;
			end
			S_SDIV: begin
				cmd.op = OP_DIV_STEP;
				if (sts.step_last) begin
					state_d = S_SCLAMP;
				end
			end
			S_SCLAMP: begin
				cmd.op  = OP_SCORE_TAKE;
				state_d = S_BLB1;
			end
			S_BLB1: begin
				cmd.op  = OP_MUL_OLD_B;
				state_d = S_BLB2;
			end
			S_BLB2: begin
				cmd.op  = OP_MUL_NEW_B;
				state_d = S_BLB3;
			end
			S_BLB3: begin
				cmd.op  = OP_SUM_B;
				state_d = S_BLA1;
			end
			S_BLA1: begin
				cmd.op  = OP_MUL_OLD_A;
				state_d = S_BLA2;
			end
			S_BLA2: begin
				cmd.op  = OP_MUL_NEW_A;
				state_d = S_BLA3;
			end
			S_BLA3: begin
				cmd.op  = OP_SUM_A;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign smp_ready = (state_q == S_IDLE);

endmodule
`default_nettype wire

[rtl/frame_energy_novelty_detector.sv]
// Top level of the frame energy novelty detector.
// Samples arrive as items on the smp channel, a frame closing at the item with
// frame_end set; one result item per frame leaves on the res channel. An item that
// does not end a frame is accepted, squared on the shared multiplier and then
// added by a saturating accumulate. A frame-end item then runs through the
// bit-serial divider for the mean square, the two-bits-per-step square root,
// the same divider again for the relative deviation, and the baseline and
// average blends (four products on the shared multiplier, two sums) before its
// result is registered. On the first frame or with a zero baseline the score
// divide is skipped. The result register frees the input side: the next frame is
// accepted while a result waits to be taken; a later frame end holds until that
// result leaves. Weights are written through the cfg port while no frame is in
// flight; the user must keep to this, as the block does not enforce it.
`default_nettype none
module frame_energy_novelty_detector
	import fend_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 smp_valid,
	output logic                      smp_ready,
	input  wire smp_item_t            smp_item,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output res_item_t                 res_item,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WGT_W-1:0]     cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	fend_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_ready (smp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fend_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.smp_item  (smp_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
`default_nettype wire

[rtl/fend_checker.sv]
// Port-level checks for the frame energy novelty detector, bound to the top level.
`default_nettype none
module fend_checker
	import fend_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      smp_valid,
	input wire logic      smp_ready,
	input wire logic      res_valid,
	input wire logic      res_ready,
	input wire res_item_t res_item
);

	logic seen_q;

	// set once any result item has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			seen_q <= 1'b1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result item changed or dropped while stalled");

	a_first_marked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !seen_q |-> res_item.first_frame)
		else $error("first result item after reset not marked as first frame");

	a_later_unmarked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && seen_q |-> !res_item.first_frame)
		else $error("later result item marked as first frame");

	a_first_half: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.first_frame |-> res_item.frame_score == HALF_SCORE)
		else $error("first frame score is not one half");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready |=> !smp_ready)
		else $error("sample item accepted on consecutive cycles");

endmodule

bind frame_energy_novelty_detector fend_checker u_fend_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.smp_valid (smp_valid),
	.smp_ready (smp_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_item  (res_item)
);
`default_nettype wire
